[src/rtpm_pkg.sv]
// Shared types, codes and helpers for the prefix match route table.
package rtpm_pkg;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_WIPE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_HOPS_FULL = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    localparam int FLAG_DIRECT = 1;
    localparam int FLAG_STATIC = 2;
    localparam int FLAG_AUTO   = 3;

    localparam logic [1:0] SW_EXACT = 2'd0;
    localparam logic [1:0] SW_LPM   = 2'd1;
    localparam logic [1:0] SW_AUTO  = 2'd2;
    localparam logic [1:0] SW_CLEAR = 2'd3;

    localparam logic [5:0] MAX_LEN = 6'd32;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] address;
        logic [5:0]  prefix_length;
        logic [31:0] next_hop;
        logic [15:0] interface_req;
        logic [3:0]  route_flags;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] match_prefix;
        logic [5:0]  match_length;
        logic [31:0] hop_address;
        logic [15:0] hop_interface;
        logic [3:0]  hop_flags;
    } t_result;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic [31:0] dyn_hop;
        logic [15:0] dyn_port;
        logic [3:0]  dyn_marks;
        logic [3:0]  total;
    } t_entry;

    typedef struct packed {
        logic [31:0] hop;
        logic [15:0] port;
        logic [3:0]  marks;
    } t_hop;

    typedef struct packed {
        logic       load;
        logic       sweep;
        logic [1:0] sw_kind;
        logic       take_auto;
        logic       sel_hit;
        logic       new_ent;
        logic       take_ent;
        logic       set_dyn;
        logic       zero_dyn;
        logic       tot_zero;
        logic       k_zero;
        logic       k_inc;
        logic       del_hit;
        logic       mv_last;
        logic       wr_st_new;
        logic       wr_ent;
        logic       free_chk;
        logic       clr_all;
        logic       res_dyn;
        logic       res_st;
        logic       st_take;
        logic       wb_auto;
        logic       set_status;
        logic [1:0] status;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] flags;
        logic       gw_zero;
        logic       sw_done;
        logic       hit;
        logic       free;
        logic       full_st;
        logic       k_end;
        logic       dyn_live;
        logic       st_port_nz;
        logic       st_auto;
        logic       st_match;
        logic       auto_nz;
        logic       old_dir;
    } t_stat;

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        return (len == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (MAX_LEN - len));
    endfunction

endpackage

[src/route_table_prefix_match_top.sv]
// Top level of the IPv4 longest prefix match route table.
//
// A request is taken on a clock edge with start high and busy low. Its
// mode selects add, delete, lookup or wipe of the whole table. Each request
// gives exactly one result on o_result, flagged by o_done for a single cycle;
// the receiver cannot stall, so the result must be captured then.
// Every table search is a sweep over all TABLE_ENTRIES slots of the entry
// memory, one slot a cycle. Lookup: one sweep, plus one more sweep for each
// static hop that needs its interface resolved. Add: one sweep, or two with
// an auto-interface hop. Changing a direct route adds a pass over every
// static hop slot.
// busy stays high from acceptance until the result cycle, in which a new
// request may already be taken.
// Reset clears the valid bits; no clearing pass is needed and the table is
// empty and ready right after reset.
module route_table_prefix_match_top #(
    parameter int TABLE_ENTRIES = 256,
    parameter int STATIC_HOPS   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rtpm_pkg::t_req    i_request,
    output logic              o_done,
    output rtpm_pkg::t_result o_result
);
    import rtpm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rtpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_request.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rtpm_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .STATIC_HOPS   (STATIC_HOPS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .o_result  (o_result),
        .o_done    (o_done)
    );
endmodule

[src/rtpm_ram.sv]
// Generic single write port RAM with registered read.
module rtpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/rtpm_ctrl.sv]
// Controller state machine sequencing add, delete, lookup and wipe.
module rtpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_mode,
    input  rtpm_pkg::t_stat i_stat,
    output rtpm_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import rtpm_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_AUTO_A = 5'd1;
    localparam logic [4:0] S_AUTO_W = 5'd2;
    localparam logic [4:0] S_FIND   = 5'd3;
    localparam logic [4:0] S_FIND_W = 5'd4;
    localparam logic [4:0] S_RD     = 5'd5;
    localparam logic [4:0] S_TAKE   = 5'd6;
    localparam logic [4:0] S_ADD    = 5'd7;
    localparam logic [4:0] S_DEL    = 5'd8;
    localparam logic [4:0] S_DK     = 5'd9;
    localparam logic [4:0] S_DK2    = 5'd10;
    localparam logic [4:0] S_DL     = 5'd11;
    localparam logic [4:0] S_DL2    = 5'd12;
    localparam logic [4:0] S_WR_ENT = 5'd13;
    localparam logic [4:0] S_CLR    = 5'd14;
    localparam logic [4:0] S_CLR_W  = 5'd15;
    localparam logic [4:0] S_FREE   = 5'd16;
    localparam logic [4:0] S_LPM    = 5'd17;
    localparam logic [4:0] S_LPM_W  = 5'd18;
    localparam logic [4:0] S_LK     = 5'd19;
    localparam logic [4:0] S_LS     = 5'd20;
    localparam logic [4:0] S_LS2    = 5'd21;
    localparam logic [4:0] S_LA     = 5'd22;
    localparam logic [4:0] S_LA_W   = 5'd23;
    localparam logic [4:0] S_WIPE   = 5'd24;
    localparam logic [4:0] S_EMIT   = 5'd25;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_mode)
                        MODE_ADD:    n_state = S_AUTO_A;
                        MODE_DELETE: n_state = S_FIND;
                        MODE_LOOKUP: n_state = S_LPM;
                        default:     n_state = S_WIPE;
                    endcase
                end
            end
            S_AUTO_A: begin
                if (i_stat.flags[FLAG_AUTO]) begin
                    o_cmd.sweep   = 1'b1;
                    o_cmd.sw_kind = SW_AUTO;
                    n_state       = S_AUTO_W;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_AUTO_W: begin
                if (i_stat.sw_done) begin
                    o_cmd.take_auto = 1'b1;
                    n_state         = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.sweep   = 1'b1;
                o_cmd.sw_kind = SW_EXACT;
                n_state       = S_FIND_W;
            end
            S_FIND_W: begin
                if (i_stat.sw_done) begin
                    if (i_stat.hit) begin
                        o_cmd.sel_hit = 1'b1;
                        n_state       = S_RD;
                    end else if (i_stat.mode == MODE_ADD && i_stat.free) begin
                        o_cmd.new_ent = 1'b1;
                        n_state       = S_ADD;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = (i_stat.mode == MODE_ADD) ? ST_TABLE_FULL
                                                                     : ST_NOT_FOUND;
                        n_state          = S_EMIT;
                    end
                end
            end
            S_RD: n_state = S_TAKE;
            S_TAKE: begin
                o_cmd.take_ent = 1'b1;
                unique case (i_stat.mode)
                    MODE_ADD:    n_state = S_ADD;
                    MODE_DELETE: n_state = S_DEL;
                    default:     n_state = S_LK;
                endcase
            end
            S_ADD: begin
                if (!i_stat.flags[FLAG_STATIC]) begin
                    o_cmd.set_dyn = 1'b1;
                end else if (i_stat.full_st) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_HOPS_FULL;
                end else begin
                    o_cmd.wr_st_new = 1'b1;
                end
                n_state = S_WR_ENT;
            end
            S_DEL: begin
                if (!i_stat.flags[FLAG_STATIC]) begin
                    o_cmd.zero_dyn = 1'b1;
                    n_state        = S_WR_ENT;
                end else if (i_stat.gw_zero) begin
                    o_cmd.tot_zero = 1'b1;
                    n_state        = S_WR_ENT;
                end else begin
                    o_cmd.k_zero = 1'b1;
                    n_state      = S_DK;
                end
            end
            S_DK: n_state = i_stat.k_end ? S_WR_ENT : S_DK2;
            S_DK2: begin
                if (i_stat.st_match) begin
                    o_cmd.del_hit = 1'b1;
                    n_state       = S_DL;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_DK;
                end
            end
            S_DL: n_state = S_DL2;
            S_DL2: begin
                o_cmd.mv_last = 1'b1;
                n_state       = S_WR_ENT;
            end
            S_WR_ENT: begin
                o_cmd.wr_ent = 1'b1;
                if (i_stat.old_dir) begin
                    n_state = S_CLR;
                end else if (i_stat.mode == MODE_DELETE) begin
                    n_state = S_FREE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_CLR: begin
                o_cmd.sweep   = 1'b1;
                o_cmd.sw_kind = SW_CLEAR;
                n_state       = S_CLR_W;
            end
            S_CLR_W: begin
                if (i_stat.sw_done) begin
                    n_state = (i_stat.mode == MODE_DELETE) ? S_FREE : S_EMIT;
                end
            end
            S_FREE: begin
                o_cmd.free_chk = 1'b1;
                n_state        = S_EMIT;
            end
            S_LPM: begin
                o_cmd.sweep   = 1'b1;
                o_cmd.sw_kind = SW_LPM;
                n_state       = S_LPM_W;
            end
            S_LPM_W: begin
                if (i_stat.sw_done) begin
                    if (i_stat.hit) begin
                        o_cmd.sel_hit = 1'b1;
                        n_state       = S_RD;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOT_FOUND;
                        n_state          = S_EMIT;
                    end
                end
            end
            S_LK: begin
                if (i_stat.dyn_live) begin
                    o_cmd.res_dyn = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_FOUND;
                    o_cmd.k_zero     = 1'b1;
                    n_state          = S_LS;
                end
            end
            S_LS: n_state = i_stat.k_end ? S_EMIT : S_LS2;
            S_LS2: begin
                o_cmd.st_take = 1'b1;
                if (i_stat.st_port_nz) begin
                    o_cmd.res_st = 1'b1;
                    n_state      = S_EMIT;
                end else if (i_stat.st_auto) begin
                    n_state = S_LA;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_LS;
                end
            end
            S_LA: begin
                o_cmd.sweep   = 1'b1;
                o_cmd.sw_kind = SW_AUTO;
                n_state       = S_LA_W;
            end
            S_LA_W: begin
                if (i_stat.sw_done) begin
                    if (i_stat.auto_nz) begin
                        o_cmd.wb_auto = 1'b1;
                        n_state       = S_EMIT;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_LS;
                    end
                end
            end
            S_WIPE: begin
                o_cmd.clr_all = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[src/rtpm_dpath.sv]
// Datapath: entry and static hop memories, table sweep engine, result register.
module rtpm_dpath #(
    parameter int TABLE_ENTRIES = 256,
    parameter int STATIC_HOPS   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rtpm_pkg::t_req    i_request,
    input  rtpm_pkg::t_cmd    i_cmd,
    output rtpm_pkg::t_stat   o_stat,
    output rtpm_pkg::t_result o_result,
    output logic              o_done
);
    import rtpm_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int SA_W  = $clog2(TABLE_ENTRIES * STATIC_HOPS);
    localparam int ENT_W = $bits(t_entry);
    localparam int HOP_W = $bits(t_hop);
    localparam logic [IDX_W-1:0] LAST_E = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [3:0]       HOPS   = 4'(STATIC_HOPS);
    localparam logic [3:0]       LAST_K = 4'(STATIC_HOPS - 1);

    function automatic logic [SA_W-1:0] f_slot(input logic [IDX_W-1:0] idx,
                                               input logic [3:0] k);
        return SA_W'(idx * STATIC_HOPS + k);
    endfunction

    logic [TABLE_ENTRIES-1:0] r_valid;
    t_req             r_req;
    logic [31:0]      r_pfx;
    logic [15:0]      r_port;
    t_entry           r_ent;
    t_hop             r_st;
    logic [IDX_W-1:0] r_idx;
    logic [3:0]       r_k;
    logic [3:0]       r_dst;
    logic             r_old_dir;
    t_result          r_res;
    logic             r_strobe;

    // sweep engine
    logic             r_sw_run;
    logic [1:0]       r_sw_kind;
    logic [31:0]      r_sw_key;
    logic [IDX_W-1:0] r_sw_e;
    logic [3:0]       r_sw_k;
    logic             r_p_v;
    logic             r_p_last;
    logic [IDX_W-1:0] r_p_e;
    logic [3:0]       r_p_k;
    logic [SA_W-1:0]  r_p_s;
    logic             r_sw_done;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [5:0]       r_best;
    logic [15:0]      r_auto_port;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    t_entry           ent_q;
    t_hop             st_q;
    logic [IDX_W-1:0] ent_raddr;
    logic [SA_W-1:0]  st_raddr;
    logic             st_we;
    logic [SA_W-1:0]  st_waddr;
    t_hop             st_wdata;
    logic             sw_last;
    logic             p_valid;
    logic             cov;
    logic             clr_hit;
    logic [5:0]       len_sat;

    assign len_sat   = (i_request.prefix_length > MAX_LEN) ? MAX_LEN
                                                           : i_request.prefix_length;
    assign ent_raddr = r_sw_run ? r_sw_e : r_idx;
    assign st_raddr  = r_sw_run ? f_slot(r_sw_e, r_sw_k) : f_slot(r_idx, r_k);
    assign sw_last   = (r_sw_e == LAST_E) && (r_sw_kind != SW_CLEAR || r_sw_k == LAST_K);
    assign p_valid   = r_valid[r_p_e];
    assign cov       = ((r_sw_key & len_mask(ent_q.length)) == ent_q.prefix);
    assign clr_hit   = r_p_v && r_sw_kind == SW_CLEAR && p_valid
                       && r_p_k < ent_q.total && st_q.marks[FLAG_AUTO];

    always_comb begin
        st_we    = 1'b0;
        st_waddr = f_slot(r_idx, r_k);
        st_wdata = st_q;
        if (clr_hit) begin
            st_we    = 1'b1;
            st_waddr = r_p_s;
            st_wdata = '{hop: st_q.hop, port: 16'h0, marks: st_q.marks};
        end else if (i_cmd.wr_st_new) begin
            st_we    = 1'b1;
            st_waddr = f_slot(r_idx, r_ent.total);
            st_wdata = '{hop: r_req.next_hop, port: r_port, marks: r_req.route_flags};
        end else if (i_cmd.mv_last) begin
            st_we    = 1'b1;
            st_waddr = f_slot(r_idx, r_dst);
        end else if (i_cmd.wb_auto) begin
            st_we    = 1'b1;
            st_wdata = '{hop: r_st.hop, port: r_auto_port, marks: r_st.marks};
        end
    end

    rtpm_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_ent),
        .i_waddr (r_idx),
        .i_wdata (r_ent),
        .i_raddr (ent_raddr),
        .o_rdata (ent_q)
    );

    rtpm_ram #(.WIDTH(HOP_W), .DEPTH(TABLE_ENTRIES * STATIC_HOPS)) u_hop_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    // control state of the sweep engine and table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_sw_run  <= 1'b0;
            r_p_v     <= 1'b0;
            r_p_last  <= 1'b0;
            r_sw_done <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe  <= i_cmd.emit;
            r_p_v     <= r_sw_run;
            r_p_last  <= r_sw_run && sw_last;
            r_sw_done <= r_p_v && r_p_last;
            if (i_cmd.sweep) begin
                r_sw_run <= 1'b1;
            end else if (r_sw_run && sw_last) begin
                r_sw_run <= 1'b0;
            end
            if (i_cmd.clr_all) begin
                r_valid <= '0;
            end else if (i_cmd.new_ent) begin
                r_valid[r_free_idx] <= 1'b1;
            end else if (i_cmd.free_chk && r_ent.total == 4'd0 && r_ent.dyn_port == 16'h0) begin
                r_valid[r_idx] <= 1'b0;
            end
        end
    end

    // sweep counters and match tracking
    always_ff @(posedge i_clk) begin
        r_p_e <= r_sw_e;
        r_p_k <= r_sw_k;
        r_p_s <= st_raddr;
        if (i_cmd.sweep) begin
            r_sw_kind <= i_cmd.sw_kind;
            r_sw_e    <= '0;
            r_sw_k    <= '0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            unique case (i_cmd.sw_kind)
                SW_EXACT: r_sw_key <= r_pfx;
                SW_LPM:   r_sw_key <= r_req.address;
                default:  r_sw_key <= (r_req.mode == MODE_LOOKUP) ? r_st.hop : r_req.next_hop;
            endcase
        end else if (r_sw_run) begin
            if (r_sw_kind == SW_CLEAR && r_sw_k != LAST_K) begin
                r_sw_k <= r_sw_k + 4'd1;
            end else begin
                r_sw_k <= '0;
                r_sw_e <= r_sw_e + IDX_W'(1);
            end
        end
        if (r_p_v) begin
            case (r_sw_kind) inside
                SW_EXACT: begin
                    if (p_valid && ent_q.prefix == r_sw_key
                        && ent_q.length == r_req.prefix_length) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_p_e;
                    end
                    if (!p_valid && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_p_e;
                    end
                end
                SW_LPM, SW_AUTO: begin
                    // longest covering entry; auto resolve needs a direct hop
                    if (p_valid && cov
                        && (r_sw_kind == SW_LPM || ent_q.dyn_marks[FLAG_DIRECT])
                        && (!r_hit || ent_q.length > r_best)) begin
                        r_hit       <= 1'b1;
                        r_hit_idx   <= r_p_e;
                        r_best      <= ent_q.length;
                        r_auto_port <= ent_q.dyn_port;
                    end
                end
                default: ;
            endcase
        end
    end

    // request, working entry and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= '{mode: i_request.mode, address: i_request.address,
                           prefix_length: len_sat, next_hop: i_request.next_hop,
                           interface_req: i_request.interface_req,
                           route_flags: i_request.route_flags};
            r_pfx     <= i_request.address & len_mask(len_sat);
            r_port    <= i_request.interface_req;
            r_old_dir <= 1'b0;
            r_res     <= '0;
        end
        if (i_cmd.take_auto && r_hit) begin
            r_port <= r_auto_port;
        end
        if (i_cmd.sel_hit) begin
            r_idx <= r_hit_idx;
        end
        if (i_cmd.new_ent) begin
            r_idx <= r_free_idx;
            r_ent <= '{prefix: r_pfx, length: r_req.prefix_length, dyn_hop: 32'h0,
                       dyn_port: 16'h0, dyn_marks: 4'h0, total: 4'h0};
        end
        if (i_cmd.take_ent) begin
            r_ent <= ent_q;
            if (r_req.mode == MODE_LOOKUP) begin
                r_res.match_prefix <= ent_q.prefix;
                r_res.match_length <= ent_q.length;
            end
        end
        if (i_cmd.set_dyn) begin
            r_ent.dyn_hop   <= r_req.next_hop;
            r_ent.dyn_port  <= r_port;
            r_ent.dyn_marks <= r_req.route_flags;
            r_old_dir       <= r_req.route_flags[FLAG_DIRECT];
        end
        if (i_cmd.zero_dyn) begin
            r_ent.dyn_hop   <= 32'h0;
            r_ent.dyn_port  <= 16'h0;
            r_ent.dyn_marks <= 4'h0;
            r_old_dir       <= r_ent.dyn_marks[FLAG_DIRECT];
        end
        if (i_cmd.tot_zero) begin
            r_ent.total <= 4'h0;
        end
        if (i_cmd.wr_st_new) begin
            r_ent.total <= r_ent.total + 4'd1;
        end
        if (i_cmd.k_zero) begin
            r_k <= 4'h0;
        end
        if (i_cmd.k_inc) begin
            r_k <= r_k + 4'd1;
        end
        if (i_cmd.del_hit) begin
            // last hop moves into the freed slot
            r_ent.total <= r_ent.total - 4'd1;
            r_dst       <= r_k;
            r_k         <= r_ent.total - 4'd1;
        end
        if (i_cmd.st_take) begin
            r_st <= st_q;
        end
        if (i_cmd.set_status) begin
            r_res.status <= i_cmd.status;
        end
        if (i_cmd.res_dyn) begin
            r_res.status        <= ST_OK;
            r_res.hop_address   <= r_ent.dyn_hop;
            r_res.hop_interface <= r_ent.dyn_port;
            r_res.hop_flags     <= r_ent.dyn_marks;
        end
        if (i_cmd.res_st) begin
            r_res.status        <= ST_OK;
            r_res.hop_address   <= st_q.hop;
            r_res.hop_interface <= st_q.port;
            r_res.hop_flags     <= st_q.marks;
        end
        if (i_cmd.wb_auto) begin
            r_res.status        <= ST_OK;
            r_res.hop_address   <= r_st.hop;
            r_res.hop_interface <= r_auto_port;
            r_res.hop_flags     <= r_st.marks;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.mode       = r_req.mode;
        o_stat.flags      = r_req.route_flags;
        o_stat.gw_zero    = (r_req.next_hop == 32'h0);
        o_stat.sw_done    = r_sw_done;
        o_stat.hit        = r_hit;
        o_stat.free       = r_free;
        o_stat.full_st    = (r_ent.total >= HOPS);
        o_stat.k_end      = (r_k >= r_ent.total) || (r_k >= HOPS);
        o_stat.dyn_live   = (r_ent.dyn_port != 16'h0);
        o_stat.st_port_nz = (st_q.port != 16'h0);
        o_stat.st_auto    = st_q.marks[FLAG_AUTO];
        o_stat.st_match   = (st_q.hop == r_req.next_hop);
        o_stat.auto_nz    = r_hit && (r_auto_port != 16'h0);
        o_stat.old_dir    = r_old_dir;
    end

    assign o_result = r_res;
    assign o_done   = r_strobe;
endmodule

[src/rtpm_checker.sv]
// Port level checks for the route table, bound to the top level.
module rtpm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input rtpm_pkg::t_req    i_request,
    input logic              o_done,
    input rtpm_pkg::t_result o_result
);
    import rtpm_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe outside a finished request");

    a_wipe_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_request.mode == MODE_WIPE
        |=> ##2 (o_done && o_result.status == ST_OK))
        else $error("wipe did not complete with ok status");

    a_no_extra_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
endmodule

bind route_table_prefix_match_top rtpm_checker u_rtpm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_request (i_request),
    .o_done    (o_done),
    .o_result  (o_result)
);

[tb/sv/route_table_prefix_match_top_test.sv]
// Self-checking testbench for the prefix match route table: directed and random requests.
module route_table_prefix_match_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rtpm_pkg::*;

    localparam int N_ENT    = 256;
    localparam int N_HOPS   = 8;
    localparam int N_RANDOM = 900;
    localparam int STALL_LIMIT = 40000;
    localparam logic [3:0] F_UP     = 4'b0001;
    localparam logic [3:0] F_DIRECT = 4'b0010;
    localparam logic [3:0] F_STATIC = 4'b0100;
    localparam logic [3:0] F_AUTO   = 4'b1000;

    // Route table shadow plus the queue of results still owed by the block.
    class route_scoreboard;
        bit          valid [N_ENT];
        logic [31:0] pfx   [N_ENT];
        logic [5:0]  plen  [N_ENT];
        logic [31:0] dhop  [N_ENT];
        logic [15:0] dport [N_ENT];
        logic [3:0]  dmark [N_ENT];
        int          stot  [N_ENT];
        logic [31:0] shop  [N_ENT][N_HOPS];
        logic [15:0] sport [N_ENT][N_HOPS];
        logic [3:0]  smark [N_ENT][N_HOPS];
        t_result     owed[$];
        int          errors;

        function logic [31:0] mask_of(int len);
            if (len == 0) return 32'h0;
            return 32'hFFFF_FFFF << (32 - len);
        endfunction

        function int find_route(logic [31:0] p, int len);
            for (int e = 0; e < N_ENT; e++)
                if (valid[e] && pfx[e] == p && plen[e] == len) return e;
            return -1;
        endfunction

        // Interface of the longest covering direct route, -1 if none.
        function int direct_port(logic [31:0] gw);
            int e;
            for (int l = 32; l >= 0; l--) begin
                e = find_route(gw & mask_of(l), l);
                if (e >= 0 && dmark[e][1]) return dport[e];
            end
            return -1;
        endfunction

        function void drop_auto_ports();
            for (int e = 0; e < N_ENT; e++)
                if (valid[e])
                    for (int k = 0; k < stot[e]; k++)
                        if (smark[e][k][3]) sport[e][k] = 16'h0;
        endfunction

        function void note_request(t_req r);
            t_result res;
            int len, e, k, p;
            logic [31:0] p32;
            logic [15:0] port;
            logic [3:0] old;
            res = '0;
            len = (r.prefix_length > 32) ? 32 : r.prefix_length;
            port = r.interface_req;
            case (r.mode)
                MODE_ADD: begin
                    p32 = r.address & mask_of(len);
                    if (r.route_flags[3]) begin
                        p = direct_port(r.next_hop);
                        if (p >= 0) port = 16'(p);
                    end
                    e = find_route(p32, len);
                    if (e < 0) begin
                        for (k = 0; k < N_ENT; k++) if (!valid[k]) break;
                        if (k < N_ENT) begin
                            e = k;
                            valid[e] = 1; pfx[e] = p32; plen[e] = 6'(len);
                            dhop[e] = 0; dport[e] = 0; dmark[e] = 0; stot[e] = 0;
                        end
                    end
                    if (e < 0) res.status = ST_TABLE_FULL;
                    else if (!r.route_flags[2]) begin
                        dhop[e] = r.next_hop; dport[e] = port; dmark[e] = r.route_flags;
                        if (r.route_flags[1]) drop_auto_ports();
                    end else if (stot[e] >= N_HOPS) res.status = ST_HOPS_FULL;
                    else begin
                        shop[e][stot[e]] = r.next_hop;
                        sport[e][stot[e]] = port;
                        smark[e][stot[e]] = r.route_flags;
                        stot[e]++;
                    end
                end
                MODE_DELETE: begin
                    e = find_route(r.address & mask_of(len), len);
                    if (e < 0) res.status = ST_NOT_FOUND;
                    else begin
                        if (r.route_flags[2]) begin
                            if (r.next_hop == 0) stot[e] = 0;
                            else
                                for (k = 0; k < stot[e]; k++)
                                    if (shop[e][k] == r.next_hop) begin
                                        stot[e]--;
                                        shop[e][k] = shop[e][stot[e]];
                                        sport[e][k] = sport[e][stot[e]];
                                        smark[e][k] = smark[e][stot[e]];
                                        break;
                                    end
                        end else begin
                            old = dmark[e];
                            dhop[e] = 0; dport[e] = 0; dmark[e] = 0;
                            if (old[1]) drop_auto_ports();
                        end
                        if (stot[e] == 0 && dport[e] == 0) valid[e] = 0;
                    end
                end
                MODE_LOOKUP: begin
                    e = -1;
                    for (int l = 32; l >= 0 && e < 0; l--)
                        e = find_route(r.address & mask_of(l), l);
                    res.status = ST_NOT_FOUND;
                    if (e >= 0) begin
                        res.match_prefix = pfx[e];
                        res.match_length = plen[e];
                        if (dport[e] != 0) begin
                            res.hop_address = dhop[e];
                            res.hop_interface = dport[e];
                            res.hop_flags = dmark[e];
                            res.status = ST_OK;
                        end else
                            for (k = 0; k < stot[e]; k++) begin
                                p = sport[e][k];
                                if (p == 0 && smark[e][k][3]) begin
                                    if (direct_port(shop[e][k]) >= 0)
                                        p = direct_port(shop[e][k]);
                                end
                                if (p != 0) begin
                                    sport[e][k] = 16'(p);   // resolved interface sticks
                                    res.hop_address = shop[e][k];
                                    res.hop_interface = 16'(p);
                                    res.hop_flags = smark[e][k];
                                    res.status = ST_OK;
                                    break;
                                end
                            end
                    end
                end
                default: for (int i = 0; i < N_ENT; i++) valid[i] = 0;
            endcase
            owed.push_back(res);
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_result a);
            t_result x;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, a);
                errors++;
                return;
            end
            x = owed.pop_front();
            cmp("status", x.status, a.status);
            cmp("match_prefix", x.match_prefix, a.match_prefix);
            cmp("match_length", x.match_length, a.match_length);
            cmp("hop_address", x.hop_address, a.hop_address);
            cmp("hop_interface", x.hop_interface, a.hop_interface);
            cmp("hop_flags", x.hop_flags, a.hop_flags);
        endfunction
    endclass

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    start = 0;
    logic    busy;
    t_req    i_request = '0;
    logic    o_done;
    t_result o_result;

    route_scoreboard sb = new();
    logic [31:0] net_pool [16];
    logic [31:0] gw_pool  [8];
    bit          quiet_run;
    int          stall_cnt;

    route_table_prefix_match_top u_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_request, .o_done, .o_result
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk)
        if (i_rst_n && o_done) sb.check_result(o_result);

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_LIMIT) begin
            $display("route_table_prefix_match_top verification failed");
            $finish;
        end
    end

    // Drive one request and hold it until the block takes it.
    task send(t_req r);
        if (!quiet_run && $urandom_range(99) < 11) begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1;
        i_request <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(r);
    endtask

    function t_req mk(logic [1:0] m, logic [31:0] a, logic [5:0] l, logic [31:0] g,
                      logic [15:0] p, logic [3:0] f);
        t_req r;
        r.mode = m; r.address = a; r.prefix_length = l;
        r.next_hop = g; r.interface_req = p; r.route_flags = f;
        return r;
    endfunction

    function t_req rand_request();
        t_req r;
        int pick;
        r.mode = ($urandom_range(99) < 40) ? MODE_ADD :
                 ($urandom_range(99) < 35) ? MODE_DELETE :
                 ($urandom_range(99) < 97) ? MODE_LOOKUP : MODE_WIPE;
        if ($urandom_range(99) < 10) begin
            // noise: anything the fields allow
            r.address = $urandom; r.prefix_length = 6'($urandom); r.next_hop = $urandom;
            r.interface_req = 16'($urandom); r.route_flags = 4'($urandom);
            if (r.route_flags[1] && $urandom_range(3) != 0) r.route_flags[1] = 0;
            return r;
        end
        pick = $urandom_range(15);
        r.address = net_pool[pick] ^ ($urandom_range(3) == 0 ? $urandom_range(255) : 0);
        pick = $urandom_range(9);
        r.prefix_length = (pick < 2) ? 6'd0 : (pick < 5) ? 6'd32 :
                          (pick < 8) ? 6'(8 * $urandom_range(1, 3)) : 6'($urandom_range(33));
        r.next_hop = ($urandom_range(9) == 0) ? 32'h0 : gw_pool[$urandom_range(7)];
        r.interface_req = ($urandom_range(4) == 0) ? 16'h0 : 16'($urandom);
        r.route_flags = 4'($urandom);
        // direct changes trigger a full hop sweep; keep them rare
        if ($urandom_range(99) >= 8) r.route_flags[1] = 0;
        return r;
    endfunction

    initial begin
        for (int i = 0; i < 16; i++) net_pool[i] = $urandom;
        for (int i = 0; i < 8; i++)
            gw_pool[i] = (i < 4) ? net_pool[i] ^ $urandom_range(255) : $urandom;
        quiet_run = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed part
        send(mk(MODE_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0));                 // empty table
        send(mk(MODE_ADD, 32'h0A01_0203, 24, 32'hC0A8_0001, 16'hFFFF, F_UP));
        send(mk(MODE_LOOKUP, 32'h0A01_02FF, 0, 0, 0, 0));
        send(mk(MODE_ADD, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 16'h1, 0)); // length saturates
        send(mk(MODE_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0));
        send(mk(MODE_ADD, 32'h0, 0, 32'h1, 16'h0, 0));                    // empty entry kept
        send(mk(MODE_LOOKUP, 32'h1234_5678, 0, 0, 0, 0));
        send(mk(MODE_ADD, 32'hC0A8_0000, 16, 32'h0, 16'h0042, F_DIRECT));
        send(mk(MODE_ADD, 32'h0, 0, 32'hC0A8_0009, 16'h0, F_STATIC | F_AUTO));
        send(mk(MODE_ADD, 32'h0, 0, 32'h0B00_0001, 16'h0007, F_STATIC));
        send(mk(MODE_LOOKUP, 32'h1234_5678, 0, 0, 0, 0));                 // auto resolve
        send(mk(MODE_DELETE, 32'hC0A8_0000, 16, 0, 0, 0));                 // direct gone
        send(mk(MODE_LOOKUP, 32'h1234_5678, 0, 0, 0, 0));
        send(mk(MODE_DELETE, 32'h0, 0, 32'hC0A8_0009, 0, F_STATIC));       // last hop moves
        send(mk(MODE_DELETE, 32'h0, 0, 32'h9999_9999, 0, F_STATIC));       // absent gateway
        send(mk(MODE_DELETE, 32'h0, 0, 32'h0, 0, F_STATIC));               // all static hops
        send(mk(MODE_DELETE, 32'h0, 0, 32'h0, 0, 0));                      // entry freed
        send(mk(MODE_DELETE, 32'h0505_0000, 16, 0, 0, 0));                 // missing entry
        for (int i = 0; i < 9; i++)                                          // static list full
            send(mk(MODE_ADD, 32'h0A01_0200, 24, 32'h100 + i, 16'(i), F_STATIC));
        send(mk(MODE_LOOKUP, 32'h0A01_0201, 0, 0, 0, 0));
        send(mk(MODE_WIPE, 0, 0, 0, 0, 0));

        // fill the table, then one more
        quiet_run = 1;
        for (int i = 0; i <= N_ENT; i++)
            send(mk(MODE_ADD, 32'h0C00_0000 + i, 32, 32'h1, 16'h1, 0));
        send(mk(MODE_WIPE, 0, 0, 0, 0, 0));
        quiet_run = 0;

        for (int i = 0; i < N_RANDOM; i++) begin
            quiet_run = (i >= 500 && i < 700);
            send(rand_request());
        end
        start <= 0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("route_table_prefix_match_top verification clean");
        else
            $display("route_table_prefix_match_top verification failed");
        $finish;
    end
endmodule

[filelist.f]
src/rtpm_pkg.sv
src/rtpm_ram.sv
src/rtpm_ctrl.sv
src/rtpm_dpath.sv
src/route_table_prefix_match_top.sv
src/rtpm_checker.sv
tb/sv/route_table_prefix_match_top_test.sv
